// File: hdl/keyword_line_tokenizer_unit_macros.svh
// ---------------------------------------------------------------------------
// keyword line tokenizer unit assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef KEYWORD_LINE_TOKENIZER_UNIT_MACROS_SVH
`define KEYWORD_LINE_TOKENIZER_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define KLTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define KLTU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/kltu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kltu_pkg
// types, constants and keyword tables of the keyword line tokenizer
// ---------------------------------------------------------------------------
package kltu_pkg;

  localparam int LINE_BUFFER_DEFAULT = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  // keyword lengths: "//", "HMM", "COMPO"
  localparam logic [2:0] KW_LEN [3] = '{3'd2, 3'd3, 3'd5};

  typedef enum logic [2:0] {
    KIND_NEWLINE = 3'd0,
    KIND_SLASH   = 3'd1,
    KIND_HMM     = 3'd2,
    KIND_COMPO   = 3'd3,
    KIND_WORD    = 3'd4,
    KIND_EOF     = 3'd5
  } kind_t;

  // one classified input item: up to three results, in this order
  typedef struct packed {
    logic        has_word;
    kind_t       word_kind;
    logic [7:0]  word_start;
    logic [7:0]  word_len;
    logic        has_nl;
    logic [7:0]  nl_col;
    logic        has_eof;
    logic [31:0] line_count;
  } job_t;

  // expected character of keyword k at position idx
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: c = 8'h2F;
      2'd1: begin
        case (idx)
          3'd0:    c = 8'h48;
          default: c = 8'h4D;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    c = 8'h43;
          3'd1:    c = 8'h4F;
          3'd2:    c = 8'h4D;
          3'd3:    c = 8'h50;
          default: c = 8'h4F;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/kltu_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kltu_front
// byte classification, chunk and token state, job generation
// ---------------------------------------------------------------------------
module kltu_front #(
  parameter int LINE_BUFFER = kltu_pkg::LINE_BUFFER_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             has_byte,
  input  logic             is_last,
  input  logic             queue_full,
  output logic             push,
  output kltu_pkg::job_t   job
);

  localparam int COL_W = $clog2(LINE_BUFFER);
  localparam int CHUNK_MAX = LINE_BUFFER - 2;

  logic [COL_W-1:0] column;
  logic             in_token;
  logic [COL_W-1:0] token_start;
  logic [COL_W-1:0] token_len;
  logic [2:0]       keyword_alive;
  logic [31:0]      lines_seen;

  logic [COL_W-1:0] column_next;
  logic             in_token_next;
  logic [COL_W-1:0] token_start_next;
  logic [COL_W-1:0] token_len_next;
  logic [2:0]       keyword_alive_next;
  logic [31:0]      lines_seen_next;

  logic             is_nl, is_delim, has_nl, has_delim, has_char;
  logic [COL_W-1:0] col1, start0, len0;
  logic [2:0]       alive0, alive_m;
  logic             close_full, close_last, close_any, word_emit;
  logic             accept;
  kltu_pkg::kind_t  word_kind;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_nl     = data_byte == kltu_pkg::CHAR_NL;
    is_delim  = (data_byte == kltu_pkg::CHAR_SP) || (data_byte == kltu_pkg::CHAR_TAB) ||
                (data_byte == kltu_pkg::CHAR_CR);
    has_nl    = has_byte && is_nl;
    has_delim = has_byte && is_delim;
    has_char  = has_byte && !is_nl && !is_delim;
    col1      = has_byte ? column + COL_W'(1) : column;

    lines_seen_next = lines_seen;
    if (has_byte && (column == '0) && (lines_seen != '1)) begin
      lines_seen_next = lines_seen + 32'd1;
    end

    // a non-delimiter byte opens a token if none is open
    start0 = in_token ? token_start : column;
    len0   = in_token ? token_len : '0;
    alive0 = in_token ? keyword_alive : 3'b111;
    for (int k = 0; k < 3; k++) begin
      alive_m[k] = alive0[k] && (len0 < COL_W'(kltu_pkg::KW_LEN[k])) &&
                   (kltu_pkg::kw_char(2'(k), len0[2:0]) == data_byte);
    end

    in_token_next      = in_token;
    token_start_next   = token_start;
    token_len_next     = token_len;
    keyword_alive_next = keyword_alive;
    if (has_char) begin
      in_token_next      = 1'b1;
      token_start_next   = start0;
      token_len_next     = len0 + COL_W'(1);
      keyword_alive_next = alive_m;
    end

    close_full = has_byte && !is_nl && (col1 >= COL_W'(CHUNK_MAX));
    close_last = is_last && !has_nl && !close_full && (col1 != '0);
    close_any  = has_nl || close_full || close_last;
    word_emit  = in_token_next && (has_nl || has_delim || close_full || close_last);

    word_kind = kltu_pkg::KIND_WORD;
    if (keyword_alive_next[0] && (token_len_next == COL_W'(kltu_pkg::KW_LEN[0]))) begin
      word_kind = kltu_pkg::KIND_SLASH;
    end
    if (keyword_alive_next[1] && (token_len_next == COL_W'(kltu_pkg::KW_LEN[1]))) begin
      word_kind = kltu_pkg::KIND_HMM;
    end
    if (keyword_alive_next[2] && (token_len_next == COL_W'(kltu_pkg::KW_LEN[2]))) begin
      word_kind = kltu_pkg::KIND_COMPO;
    end

    job.has_word   = word_emit;
    job.word_kind  = word_kind;
    job.word_start = 8'(token_start_next);
    job.word_len   = 8'(token_len_next);
    job.has_nl     = close_any;
    job.nl_col     = has_nl ? 8'(column) : 8'(col1);
    job.has_eof    = is_last;
    job.line_count = lines_seen_next;

    column_next = close_any ? '0 : col1;
    if (word_emit) begin
      in_token_next = 1'b0;
    end
  end

  assign push = accept && (word_emit || close_any || is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      in_token      <= 1'b0;
      token_start   <= '0;
      token_len     <= '0;
      keyword_alive <= 3'b111;
      lines_seen    <= '0;
    end else if (accept) begin
      column        <= column_next;
      in_token      <= in_token_next;
      token_start   <= token_start_next;
      token_len     <= token_len_next;
      keyword_alive <= keyword_alive_next;
      lines_seen    <= lines_seen_next;
    end
  end

endmodule

// File: hdl/kltu_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kltu_fifo
// short job queue between front and back
// ---------------------------------------------------------------------------
module kltu_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kltu_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output kltu_pkg::job_t head_job
);

  localparam int DEPTH = kltu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  kltu_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/kltu_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kltu_back
// splits each job into result items and holds the output register
// ---------------------------------------------------------------------------
module kltu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  kltu_pkg::job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     token_kind,
  output logic [7:0]     start_column,
  output logic [7:0]     token_length,
  output logic [31:0]    line_count,
  output logic           last_of_run
);

  typedef enum logic [1:0] {
    SLOT_WORD = 2'd0,
    SLOT_NL   = 2'd1,
    SLOT_EOF  = 2'd2
  } slot_t;

  logic [2:0]      done;
  logic [2:0]      pending;
  logic [2:0]      rest;
  logic [2:0]      sel_bit;
  slot_t           slot;
  logic            load;
  logic            is_final;
  kltu_pkg::kind_t sel_kind;
  logic [7:0]      sel_start;
  logic [7:0]      sel_len;
  kltu_pkg::kind_t out_kind;

  always_comb begin
    pending = {head_job.has_eof, head_job.has_nl, head_job.has_word} & ~done;
    if (pending[0]) begin
      slot    = SLOT_WORD;
      sel_bit = 3'b001;
    end else if (pending[1]) begin
      slot    = SLOT_NL;
      sel_bit = 3'b010;
    end else begin
      slot    = SLOT_EOF;
      sel_bit = 3'b100;
    end
    rest     = pending & ~sel_bit;
    is_final = rest == 3'b000;

    case (slot)
      SLOT_WORD: begin
        sel_kind  = head_job.word_kind;
        sel_start = head_job.word_start;
        sel_len   = head_job.word_len;
      end
      SLOT_NL: begin
        sel_kind  = kltu_pkg::KIND_NEWLINE;
        sel_start = head_job.nl_col;
        sel_len   = 8'd1;
      end
      default: begin
        sel_kind  = kltu_pkg::KIND_EOF;
        sel_start = 8'd0;
        sel_len   = 8'd0;
      end
    endcase
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= 3'b000;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= is_final ? 3'b000 : (done | sel_bit);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind     <= sel_kind;
      start_column <= sel_start;
      token_length <= sel_len;
      line_count   <= head_job.line_count;
      last_of_run  <= is_final;
    end
  end

  assign token_kind = out_kind;

endmodule

// File: hdl/keyword_line_tokenizer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyword_line_tokenizer_unit
// byte-stream tokenizer with keyword classification and line chunking
// ---------------------------------------------------------------------------
// The unit takes one text byte per item and emits token descriptors. Space,
// tab and CR separate tokens; a chunk ends at a newline byte or after
// LINE_BUFFER-2 bytes and always closes with a newline token. Words are
// classified as "//", "HMM", "COMPO" or a plain word. An item with is_last
// set closes any open chunk and adds an end-of-file token; an item with
// neither a byte nor is_last yields nothing. Each item makes zero to three
// results, the last of which carries last_of_run. Timing: the front
// accepts one item per clock whenever the two-entry job queue has room; an
// accepted item's job is written into the queue, and its results are then
// loaded one by one into the output register whenever it is free. The back
// drains one result per clock while out_ready is high; the output port is
// the sustained limit, one result per clock while it is not stalled.
// ---------------------------------------------------------------------------
module keyword_line_tokenizer_unit #(
  parameter int LINE_BUFFER = kltu_pkg::LINE_BUFFER_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  // result item channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  token_kind,
  output logic [7:0]  start_column,
  output logic [7:0]  token_length,
  output logic [31:0] line_count,
  output logic        last_of_run
);

  // front to queue
  logic           push;
  kltu_pkg::job_t push_job;
  logic           queue_full;

  // queue to back
  logic           head_valid;
  kltu_pkg::job_t head_job;
  logic           pop;

  // front: column / token tracking, keyword match bits, saturating line count
  kltu_front #(
    .LINE_BUFFER (LINE_BUFFER)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .is_last    (is_last),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  // decouples the front from output stalls
  kltu_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: word, newline, end-of-file results in order, one per clock while out_ready is high
  kltu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .start_column (start_column),
    .token_length (token_length),
    .line_count   (line_count),
    .last_of_run  (last_of_run)
  );

endmodule

// File: hdl/kltu_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kltu_checker
// port-level checks of the keyword line tokenizer unit
// ---------------------------------------------------------------------------
`include "keyword_line_tokenizer_unit_macros.svh"

module kltu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        has_byte,
  input logic        is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  token_kind,
  input logic [7:0]  start_column,
  input logic [7:0]  token_length,
  input logic [31:0] line_count,
  input logic        last_of_run
);

  // a waiting input item holds its payload
  `KLTU_ASSERT(a_in_hold, (in_valid && !in_ready) |=> (in_valid && $stable(data_byte) && $stable(has_byte) && $stable(is_last)), "input item changed while waiting")

  // a stalled result holds its payload
  `KLTU_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(token_kind) && $stable(start_column) && $stable(token_length) && $stable(line_count) && $stable(last_of_run)), "result changed while stalled")

  // end of file closes the item and carries no position or length
  `KLTU_ASSERT(a_eof_shape, (out_valid && token_kind == kltu_pkg::KIND_EOF) |-> (last_of_run && token_length == 8'd0 && start_column == 8'd0), "bad end-of-file token")

  // newline and keyword tokens have fixed lengths
  `KLTU_ASSERT(a_fixed_len, out_valid |-> ((token_kind != kltu_pkg::KIND_NEWLINE || token_length == 8'd1) && (token_kind != kltu_pkg::KIND_SLASH || token_length == 8'd2) && (token_kind != kltu_pkg::KIND_HMM || token_length == 8'd3) && (token_kind != kltu_pkg::KIND_COMPO || token_length == 8'd5)), "token length does not fit its kind")

  // line count never goes backwards when one result directly follows another
  `KLTU_ASSERT(a_lines_mono, ((out_valid && out_ready) ##1 out_valid) |-> (line_count >= $past(line_count)), "line count decreased")

endmodule

bind keyword_line_tokenizer_unit kltu_checker u_checker (.*);

// File: test/keyword_line_tokenizer_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyword_line_tokenizer_unit_test
// self-checking bench for the keyword line tokenizer
// ---------------------------------------------------------------------------
// A queue of byte items feeds a clocked driver. The driver predicts the
// token descriptors of every item it hands over, and a clocked monitor
// checks each descriptor against the oldest prediction. Directed items
// cover keywords, separators, extreme bytes and every end-of-input form.
// Random lines follow, plus one line long enough to split into chunks.
// Both sides idle at random, with calm stretches in between.
// ---------------------------------------------------------------------------
module keyword_line_tokenizer_unit_test;
  import kltu_pkg::*;

  localparam int CHUNK_BYTES    = LINE_BUFFER_DEFAULT - 2;
  localparam int RANDOM_ITEMS   = 236;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 500;

  // one byte item as the sender sees it
  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       last;
  } byte_item_t;

  // one token descriptor as the receiver sees it
  typedef struct {
    kind_t       kind;
    logic [7:0]  start;
    logic [7:0]  len;
    logic [31:0] lines;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  token_kind;
  logic [7:0]  start_column;
  logic [7:0]  token_length;
  logic [31:0] line_count;
  logic        last_of_run;

  keyword_line_tokenizer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .has_byte     (has_byte),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .start_column (start_column),
    .token_length (token_length),
    .line_count   (line_count),
    .last_of_run  (last_of_run)
  );

  always #5 clk = ~clk;

  // stimulus and predicted descriptors
  byte_item_t byte_queue[$];
  token_t     token_queue[$];
  token_t     item_tokens[$];
  logic [7:0] line_buf[$];
  int         items_queued = 0;

  // tokenizer shadow state
  int          chunk_col = 0;
  bit          in_word = 1'b0;
  int          word_start = 0;
  int          word_len = 0;
  logic [39:0] word_head = '0;
  logic [31:0] lines_seen = '0;

  // run bookkeeping
  int mismatches = 0;
  int items_accepted = 0;
  int tokens_checked = 0;
  int kind_seen [6];
  int idle_cycles = 0;

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------
  function automatic bit is_separator(input logic [7:0] b);
    return b == CHAR_SP || b == CHAR_TAB || b == CHAR_CR;
  endfunction

  task automatic emit_token(input kind_t kind, input int start, input int len);
    token_t t;
    t.kind  = kind;
    t.start = start[7:0];
    t.len   = len[7:0];
    t.lines = lines_seen;
    t.last  = 1'b0;
    item_tokens.push_back(t);
  endtask

  // pending word leaves as a keyword only on an exact full-length match
  task automatic flush_word();
    kind_t kind;
    if (in_word) begin
      kind = KIND_WORD;
      if (word_len == 2 && word_head[15:0] == "//")
        kind = KIND_SLASH;
      else if (word_len == 3 && word_head[23:0] == "HMM")
        kind = KIND_HMM;
      else if (word_len == 5 && word_head == "COMPO")
        kind = KIND_COMPO;
      emit_token(kind, word_start, word_len);
      in_word = 1'b0;
    end
  endtask

  task automatic close_chunk(input int nl_col);
    flush_word();
    emit_token(KIND_NEWLINE, nl_col, 1);
    chunk_col = 0;
  endtask

  // descriptors caused by one accepted item, in output order
  task automatic tokenize_item(input logic [7:0] b, input logic has, input logic last);
    int     pos;
    token_t t;
    if (has) begin
      pos = chunk_col;
      // first byte of a chunk bumps the saturating line count
      if (chunk_col == 0 && lines_seen != 32'hFFFF_FFFF)
        lines_seen++;
      chunk_col++;
      if (b == CHAR_NL) begin
        close_chunk(pos);
      end else begin
        if (is_separator(b)) begin
          flush_word();
        end else begin
          if (!in_word) begin
            in_word    = 1'b1;
            word_start = pos;
            word_len   = 0;
            word_head  = '0;
          end
          // only the first five bytes matter for the keywords
          if (word_len < 5)
            word_head = {word_head[31:0], b};
          word_len++;
        end
        // full chunk gets a supplied newline at its length
        if (chunk_col >= CHUNK_BYTES)
          close_chunk(chunk_col);
      end
    end
    if (last) begin
      if (chunk_col != 0)
        close_chunk(chunk_col);
      emit_token(KIND_EOF, 0, 0);
    end
    while (item_tokens.size() > 0) begin
      t = item_tokens.pop_front();
      t.last = (item_tokens.size() == 0);
      token_queue.push_back(t);
    end
  endtask

  // ------------------------------------------------------------------
  // stimulus builders
  // ------------------------------------------------------------------
  task automatic push_item(input logic [7:0] b, input logic has, input logic last);
    byte_item_t it;
    it.data = b;
    it.has  = has;
    it.last = last;
    byte_queue.push_back(it);
    // bare items are ignored by the block and do not count
    if (has || last)
      items_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_item(s[i], 1'b1, 1'b0);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++)
      line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] separator_byte();
    case ($urandom_range(0, 2))
      0:       return CHAR_SP;
      1:       return CHAR_TAB;
      default: return CHAR_CR;
    endcase
  endfunction

  // any byte that extends a word, zero and high bytes included
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (is_separator(b) || b == CHAR_NL)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // a line of keywords, near misses and random words
  task automatic build_line();
    int ntok;
    line_buf.delete();
    ntok = $urandom_range(0, 6);
    for (int t = 0; t < ntok; t++) begin
      repeat ((t == 0) ? $urandom_range(0, 2) : $urandom_range(1, 3))
        line_buf.push_back(separator_byte());
      case ($urandom_range(0, 13))
        0, 1:    append_text("//");
        2, 3:    append_text("HMM");
        4, 5:    append_text("COMPO");
        6:       append_text("HM");
        7:       append_text("COMP");
        8:       append_text("/");
        9:       append_text("HMMM");
        10:      append_text("COMPOS");
        11:      append_text("///");
        default: repeat ($urandom_range(1, 6)) line_buf.push_back(word_byte());
      endcase
    end
    repeat ($urandom_range(0, 1))
      line_buf.push_back(separator_byte());
  endtask

  // words and single separators until the chunk limit is crossed
  task automatic build_long_line();
    int target;
    line_buf.delete();
    target = CHUNK_BYTES + $urandom_range(0, 8);
    while (line_buf.size() < target) begin
      if ($urandom_range(0, 2) == 0)
        line_buf.push_back(separator_byte());
      else
        repeat ($urandom_range(1, 12)) line_buf.push_back(word_byte());
    end
  endtask

  // send line_buf with one of the ways a line can end
  task automatic send_line();
    int  ending;
    int  n;
    bit  last_on_byte;
    ending = $urandom_range(0, 19);
    if (ending <= 14)
      line_buf.push_back(CHAR_NL);
    last_on_byte = (ending == 14) || ((ending == 15 || ending == 16) && line_buf.size() > 0);
    n = line_buf.size();
    for (int i = 0; i < n; i++)
      push_item(line_buf[i], 1'b1, last_on_byte && i == n - 1);
    // bare end marker, possibly with a chunk still open
    if (ending == 17 || ((ending == 15 || ending == 16) && n == 0))
      push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // ------------------------------------------------------------------
  // driver: one item in flight, random gap after each
  // ------------------------------------------------------------------
  byte_item_t next_item;
  int         send_wait = 0;
  bit         send_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        tokenize_item(data_byte, has_byte, is_last);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          next_item = byte_queue.pop_front();
          data_byte <= next_item.data;
          has_byte  <= next_item.has;
          is_last   <= next_item.last;
          in_valid  <= 1'b1;
          if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
          send_wait = send_calm ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: random stall after each descriptor, field-by-field check
  // ------------------------------------------------------------------
  token_t want;
  int     recv_wait = 0;
  bit     recv_calm = 1'b0;

  function automatic void check_field(input string name, input logic [31:0] expected,
                                      input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        tokens_checked++;
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual kind %0d column %0d",
                   $time, token_kind, start_column);
          mismatches++;
        end else begin
          want = token_queue.pop_front();
          check_field("token_kind", want.kind, token_kind);
          check_field("start_column", want.start, start_column);
          check_field("token_length", want.len, token_length);
          check_field("line_count", want.lines, line_count);
          check_field("last_of_run", want.last, last_of_run);
          kind_seen[int'(want.kind)]++;
        end
        if ($urandom_range(0, 39) == 0)
          recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // watchdog: too long with no item moving on either side
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus, reset and end of run
  // ------------------------------------------------------------------
  initial begin
    int base;
    int long_len;
    for (int k = 0; k < 6; k++)
      kind_seen[k] = 0;

    // all keywords on one line
    push_text("// HMM COMPO\n");
    // tab and CR as separators, zero and all-ones bytes inside a word
    push_item(CHAR_TAB, 1'b1, 1'b0);
    push_item("X", 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(CHAR_CR, 1'b1, 1'b0);
    push_item(CHAR_NL, 1'b1, 1'b0);
    // bare item, ignored
    push_item(8'hA5, 1'b0, 1'b0);
    // end of input on a keyword byte: word, supplied newline, end of file
    push_text("HM");
    push_item("M", 1'b1, 1'b1);
    // bare end marker with no chunk open
    push_item(8'h5A, 1'b0, 1'b1);
    // end of input on a newline byte
    push_item(CHAR_NL, 1'b1, 1'b1);

    // random lines with some noise; one long line splits into chunks
    base     = items_queued;
    long_len = 0;
    while (items_queued - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0)
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3))
          push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      if (long_len == 0 && items_queued - base >= 12) begin
        build_long_line();
        long_len = line_buf.size();
      end else begin
        build_line();
      end
      send_line();
    end
    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all items handed over and every descriptor back
    while (byte_queue.size() != 0 || in_valid || token_queue.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (token_queue.size() != 0) begin
      $display("%0t: %0d tokens expected, actual none", $time, token_queue.size());
      mismatches += token_queue.size();
    end

    $display("covered %0d input items and %0d tokens: %0d words, %0d keywords,",
             items_accepted, tokens_checked, kind_seen[int'(KIND_WORD)],
             kind_seen[int'(KIND_SLASH)] + kind_seen[int'(KIND_HMM)] +
             kind_seen[int'(KIND_COMPO)]);
    $display("%0d newlines, %0d end-of-file tokens, %0d chunks, %0d mismatches",
             kind_seen[int'(KIND_NEWLINE)], kind_seen[int'(KIND_EOF)], lines_seen,
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/kltu_pkg.sv
hdl/kltu_front.sv
hdl/kltu_fifo.sv
hdl/kltu_back.sv
hdl/keyword_line_tokenizer_unit.sv
hdl/kltu_checker.sv
test/keyword_line_tokenizer_unit_test.sv
